// File: rtl/ppts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path point timestamper package
// Shared widths, constants and word types of the path point timestamper.
// ----------------------------------------------------------------------------
package ppts_pkg;

  localparam int COORD_W       = 32;
  localparam int VEL_W         = 32;
  localparam int TIME_W        = 48;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * COORD_W + 1;
  localparam int RAD_W         = 2 * DIFF_W;
  localparam int ROOT_W        = DIFF_W;
  localparam int REM_W         = ROOT_W + 1;
  localparam int SUB_W         = REM_W + 2;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_VELOCITY = '0;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      first_point;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [TIME_W-1:0]         time_stamp;
  } out_word_t;

endpackage

// File: rtl/ppts_seg_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment time unit
// Computes floor(floor(sqrt(dx^2 + dy^2)) << F / velocity), saturated, with
// one shared subtractor stepped by a small sequencer (restoring square root,
// then restoring division).
// ----------------------------------------------------------------------------
module ppts_seg_unit #(
  parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ppts_pkg::COORD_W-1:0] cur_x,
  input  logic signed [ppts_pkg::COORD_W-1:0] cur_y,
  input  logic signed [ppts_pkg::COORD_W-1:0] prev_x,
  input  logic signed [ppts_pkg::COORD_W-1:0] prev_y,
  input  logic [ppts_pkg::VEL_W-1:0]        velocity,
  output logic                              done,
  output logic [ppts_pkg::TIME_W-1:0]       seg_time
);
  import ppts_pkg::*;

  localparam int NUM_W = ROOT_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int EXT_W = 64;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DX   = 10'b00_0000_0010,
    S_DY   = 10'b00_0000_0100,
    S_MX   = 10'b00_0000_1000,
    S_MY   = 10'b00_0001_0000,
    S_ADD  = 10'b00_0010_0000,
    S_SQRT = 10'b00_0100_0000,
    S_PREP = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } seg_state_t;

  seg_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] cx_r, cy_r, px_r, py_r;
  logic signed [COORD_W-1:0] cx_nxt, cy_nxt, px_nxt, py_nxt;
  logic [VEL_W-1:0]          vel_r, vel_nxt;
  logic signed [DIFF_W-1:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic [SQ_W-1:0]           prod_r, prod_nxt;
  logic [RAD_W-1:0]          rad_r, rad_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [NUM_W-1:0]          num_r, num_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [TIME_W-1:0]         time_r, time_nxt;
  logic                      done_r, done_nxt;

  logic signed [DIFF_W-1:0]   mul_op;
  logic signed [2*DIFF_W-1:0] mul_out;
  logic [SUB_W-1:0]           sub_a, sub_b;
  logic [SUB_W:0]             diff;
  logic                       borrow;
  logic [EXT_W-1:0]           q_ext;

  // shared multiplier: squares dx, then dy
  assign mul_op  = state_r == S_MY ? dy_r : dx_r;
  assign mul_out = mul_op * mul_op;

  // shared subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_r)
      S_DX: begin
        sub_a = {{(SUB_W-COORD_W){cx_r[COORD_W-1]}}, cx_r};
        sub_b = {{(SUB_W-COORD_W){px_r[COORD_W-1]}}, px_r};
      end
      S_DY: begin
        sub_a = {{(SUB_W-COORD_W){cy_r[COORD_W-1]}}, cy_r};
        sub_b = {{(SUB_W-COORD_W){py_r[COORD_W-1]}}, py_r};
      end
      S_SQRT: begin
        sub_a = {rem_r, rad_r[RAD_W-1 -: 2]};
        sub_b = {1'b0, root_r, 2'b01};
      end
      S_DIV: begin
        sub_a = {{(SUB_W-VEL_W-1){1'b0}}, rem_r[VEL_W-1:0], num_r[NUM_W-1]};
        sub_b = {{(SUB_W-VEL_W){1'b0}}, vel_r};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[SUB_W];
  assign q_ext  = EXT_W'(num_r);

  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    vel_nxt   = vel_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    prod_nxt  = prod_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    time_nxt  = time_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cx_nxt    = cur_x;
          cy_nxt    = cur_y;
          px_nxt    = prev_x;
          py_nxt    = prev_y;
          vel_nxt   = velocity;
          state_nxt = S_DX;
        end
      end
      S_DX: begin
        dx_nxt    = diff[DIFF_W-1:0];
        state_nxt = S_DY;
      end
      S_DY: begin
        dy_nxt    = diff[DIFF_W-1:0];
        state_nxt = S_MX;
      end
      S_MX: begin
        prod_nxt  = mul_out[SQ_W-1:0];
        state_nxt = S_MY;
      end
      S_MY: begin
        rad_nxt   = {1'b0, prod_r};
        prod_nxt  = mul_out[SQ_W-1:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        rad_nxt   = rad_r + {1'b0, prod_r};
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = CNT_W'(ROOT_W - 1);
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
        if (!borrow) begin
          rem_nxt  = diff[REM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sub_a[REM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (vel_r == '0) begin
          time_nxt  = TIME_MAX;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          num_nxt   = {root_r, {FRAC_BITS{1'b0}}};
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(NUM_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        num_nxt = {num_r[NUM_W-2:0], ~borrow};
        if (!borrow) begin
          rem_nxt = {{(REM_W-VEL_W){1'b0}}, diff[VEL_W-1:0]};
        end else begin
          rem_nxt = {{(REM_W-VEL_W){1'b0}}, sub_a[VEL_W-1:0]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        time_nxt  = (|q_ext[EXT_W-1:TIME_W]) ? TIME_MAX : q_ext[TIME_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    vel_r  <= vel_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    prod_r <= prod_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    num_r  <= num_nxt;
    cnt_r  <= cnt_nxt;
    time_r <= time_nxt;
  end

  assign done     = done_r;
  assign seg_time = time_r;

endmodule

// File: rtl/path_point_timestamper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path point timestamper
// Emits each 2D path point with the time to reach it at constant velocity.
// ----------------------------------------------------------------------------
//  channel | ports                                    | word
//  --------+------------------------------------------+---------------------
//  in      | in_valid, in_ready, in_data              | in_word_t
//  out     | out_valid, out_ready, out_data           | out_word_t
//  cfg     | psel, penable, pwrite, paddr, pwdata,    | velocity at 0x0
//          | prdata, pready                           |
//
// A point that starts a path goes straight to the output register; any other
// point runs 33 square-root steps and, unless velocity is zero, 33 + FRAC_BITS
// division steps on the shared subtractor, plus setup and output.
// One point is in work at a time; in_ready is low from accept until the
// result is loaded into the output register, which a stalled out_ready holds.
// Reset sets velocity to 1.0 and starts with no path.
// ----------------------------------------------------------------------------
module path_point_timestamper #(
  parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ppts_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ppts_pkg::out_word_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppts_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ppts_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ppts_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import ppts_pkg::*;

  localparam logic [VEL_W-1:0] VEL_RESET = VEL_W'(64'd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_SEG  = 3'b010,
    T_OUT  = 3'b100
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic [VEL_W-1:0]          vel_r, vel_nxt;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r, prev_x_nxt, prev_y_nxt;
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic                      have_prev_r, have_prev_nxt;
  logic [TIME_W-1:0]         elapsed_r, elapsed_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_word_t                 out_data_r, out_data_nxt;

  logic              in_fire;
  logic              seg_start;
  logic              seg_done;
  logic [TIME_W-1:0] seg_time;
  logic [TIME_W:0]   time_sum;
  logic              reg_sel;
  logic              cfg_wr;

  assign in_ready  = state_r == T_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign seg_start = in_fire && !in_data.first_point && have_prev_r;
  assign time_sum  = {1'b0, elapsed_r} + {1'b0, seg_time};

  assign reg_sel = paddr[CFG_ADDR_W-1:2] == REG_VELOCITY;
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? vel_r : '0;

  ppts_seg_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (seg_start),
    .cur_x    (in_data.x_coord),
    .cur_y    (in_data.y_coord),
    .prev_x   (prev_x_r),
    .prev_y   (prev_y_r),
    .velocity (vel_r),
    .done     (seg_done),
    .seg_time (seg_time)
  );

  always_comb begin
    state_nxt     = state_r;
    vel_nxt       = cfg_wr ? pwdata[VEL_W-1:0] : vel_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    have_prev_nxt = have_prev_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_fire) begin
          cur_x_nxt     = in_data.x_coord;
          cur_y_nxt     = in_data.y_coord;
          prev_x_nxt    = in_data.x_coord;
          prev_y_nxt    = in_data.y_coord;
          have_prev_nxt = 1'b1;
          if (seg_start) begin
            state_nxt = T_SEG;
          end else begin
            elapsed_nxt = '0;
            state_nxt   = T_OUT;
          end
        end
      end
      T_SEG: begin
        if (seg_done) begin
          elapsed_nxt = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
          state_nxt   = T_OUT;
        end
      end
      T_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.out_x      = cur_x_r;
          out_data_nxt.out_y      = cur_y_r;
          out_data_nxt.time_stamp = elapsed_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      vel_r       <= VEL_RESET;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vel_r       <= vel_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      have_prev_r <= have_prev_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: bench/ppts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path point timestamper checker
// Watches the point, result and register ports, keeps its own model of the
// path time accumulation and compares every result word with the oldest
// predicted point.
// ----------------------------------------------------------------------------
module ppts_checker #(
  parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  ppts_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  ppts_pkg::out_word_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ppts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ppts_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              errors,
  output int                              pending
);
  import ppts_pkg::*;

  localparam int WIDE_W = RAD_W + 2;
  localparam int SLOTS  = 8;
  localparam logic [CFG_ADDR_W-1:0] VEL_ADDR = {REG_VELOCITY, 2'b00};

  logic [VEL_W-1:0]   velocity;
  logic [COORD_W-1:0] last_x;
  logic [COORD_W-1:0] last_y;
  logic [TIME_W-1:0]  elapsed;
  logic               have_last;
  out_word_t          stamped [SLOTS];
  int                 wr_cnt;
  int                 rd_cnt;

  // time to travel one segment: floor(sqrt(dx^2 + dy^2)) << F / velocity
  function automatic logic [TIME_W-1:0] leg_time(
    input logic [COORD_W-1:0] x0,
    input logic [COORD_W-1:0] y0,
    input logic [COORD_W-1:0] x1,
    input logic [COORD_W-1:0] y1,
    input logic [VEL_W-1:0]   vel
  );
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic [WIDE_W-1:0] sq_sum;
    logic [ROOT_W:0]   root;
    logic [ROOT_W:0]   cand;
    logic [63:0]       quo;
    dx = {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
    dy = {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
    ax = dx[DIFF_W-1] ? -dx : dx;
    ay = dy[DIFF_W-1] ? -dy : dy;
    sq_sum = WIDE_W'(ax) * WIDE_W'(ax) + WIDE_W'(ay) * WIDE_W'(ay);
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      cand = root | ((ROOT_W + 1)'(1) << b);
      if (WIDE_W'(cand) * WIDE_W'(cand) <= sq_sum) root = cand;
    end
    if (vel == '0) return TIME_MAX;
    quo = (64'(root) << FRAC_BITS) / 64'(vel);
    return (quo > 64'(TIME_MAX)) ? TIME_MAX : quo[TIME_W-1:0];
  endfunction

  always @(posedge clk) begin
    in_word_t         pt;
    out_word_t        want;
    logic [TIME_W:0]  total;
    if (!rst_n) begin
      velocity  = VEL_W'(1) << FRAC_BITS;
      last_x    = '0;
      last_y    = '0;
      elapsed   = '0;
      have_last = 1'b0;
      wr_cnt    = 0;
      rd_cnt    = 0;
      errors    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == VEL_ADDR) velocity = pwdata;

      if (out_valid && out_ready) begin
        if (wr_cnt == rd_cnt) begin
          $error("result word with no point pending: x %h y %h t %h",
                 out_data.out_x, out_data.out_y, out_data.time_stamp);
          errors++;
        end else begin
          want = stamped[rd_cnt % SLOTS];
          rd_cnt++;
          if (out_data.out_x !== want.out_x) begin
            $error("out_x: expected %h, got %h", want.out_x, out_data.out_x);
            errors++;
          end
          if (out_data.out_y !== want.out_y) begin
            $error("out_y: expected %h, got %h", want.out_y, out_data.out_y);
            errors++;
          end
          if (out_data.time_stamp !== want.time_stamp) begin
            $error("time_stamp: expected %h, got %h", want.time_stamp,
                   out_data.time_stamp);
            errors++;
          end
        end
      end

      if (in_valid && in_ready) begin
        pt = in_data;
        if (pt.first_point || !have_last) begin
          elapsed = '0;
        end else begin
          total = {1'b0, elapsed} +
                  {1'b0, leg_time(last_x, last_y, pt.x_coord, pt.y_coord, velocity)};
          elapsed = total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
        end
        last_x    = pt.x_coord;
        last_y    = pt.y_coord;
        have_last = 1'b1;
        want.out_x      = pt.x_coord;
        want.out_y      = pt.y_coord;
        want.time_stamp = elapsed;
        if (wr_cnt - rd_cnt >= SLOTS) begin
          $error("more than %0d points pending", SLOTS);
          errors++;
        end
        stamped[wr_cnt % SLOTS] = want;
        wr_cnt++;
      end
    end
    pending = wr_cnt - rd_cnt;
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path point timestamper testbench
// Drives path points and velocity settings into the timestamper with random
// idle gaps on both channels, one long result stall, and checks results
// through the checker module.
// ----------------------------------------------------------------------------
module tb;
  import ppts_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 100;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_WORDS = 290;
  localparam logic [CFG_ADDR_W-1:0] VEL_ADDR = {REG_VELOCITY, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int   errors;
  int   pending;
  int   rd_errors;
  int   cycles;
  bit   burst;
  bit   long_hold;

  path_point_timestamper u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ppts_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // result side
  initial begin
    int stall;
    bit late;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 17);
      late  = $urandom_range(0, 1);
      if (long_hold) begin
        long_hold = 1'b0;
        stall     = LONG_HOLD;
        late      = 1'b0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        if (late) begin
          do @(posedge clk); while (!out_valid);
          @(negedge clk);
        end
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // entered and left at a falling edge
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic fp);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_data.x_coord     <= x;
    in_data.y_coord     <= y;
    in_data.first_point <= fp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_velocity(input logic [VEL_W-1:0] v);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VEL_ADDR;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== v) begin
      $error("velocity readback: expected %h, got %h", v, prdata);
      rd_errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] near);
    int step;
    step = $urandom_range(0, 1 << 20) - (1 << 19);
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return near + step;
    endcase
  endfunction

  initial begin
    logic [VEL_W-1:0]   vel_list [6];
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    int                 sent;
    int                 path_len;
    bit                 fp;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    rd_errors = 0;
    burst     = 1'b0;
    long_hold = 1'b0;
    cur_x     = '0;
    cur_y     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no path yet: a plain point starts one
    send_point(32'h0005_0000, 32'h0007_0000, 1'b0);
    send_point(32'h0008_0000, 32'h000B_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0000_0001, 32'h0000_0000, 1'b0);
    send_point(32'hFFFF_0000, 32'h0001_0000, 1'b1);
    send_point(32'h0003_0000, 32'hFFFC_0000, 1'b0);

    // slowest speed: segment and path times saturate
    set_velocity(32'h0000_0001);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_0000, 32'h7FFF_0000, 1'b1);
    send_point(32'h7FFF_0100, 32'h7FFF_0000, 1'b0);
    send_point(32'h8000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);

    set_velocity(32'hFFFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h1234_5678, 32'h9ABC_DEF0, 1'b0);

    vel_list[0] = 32'h0001_0000;
    vel_list[1] = 32'h0000_0001;
    vel_list[2] = 32'hFFFF_FFFF;
    vel_list[3] = $urandom_range(1, 255);
    vel_list[4] = $urandom;
    vel_list[5] = $urandom_range(1 << 12, 1 << 24);
    if (vel_list[4] == '0) vel_list[4] = 32'h0000_0001;

    for (int p = 0; p < 6; p++) begin
      set_velocity(vel_list[p]);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        path_len = $urandom_range(1, 24);
        burst    = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < path_len; k++) begin
          cur_x = pick_coord(cur_x);
          cur_y = pick_coord(cur_y);
          if (k == 0) fp = ($urandom_range(0, 9) != 0);
          else        fp = ($urandom_range(0, 29) == 0);
          if (p == 0 && sent == 100) long_hold = 1'b1;
          send_point(cur_x, cur_y, fp);
          sent++;
        end
      end
      burst = 1'b0;
    end

    wait_idle();
    if (errors == 0 && rd_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
